/* src/cve_pkg.sv */
// ----------------------------------------------------------------------------
// cve_pkg: shared types, constants and helpers
// Widths, register codes, configuration and job types, and the fixed-point
// saturation helpers used by the cubic escape-time core.
// ----------------------------------------------------------------------------
package cve_pkg;

	localparam int FRAC_BITS   = 26;
	localparam int COORD_WIDTH = 11;
	localparam int ITER_WIDTH  = 12;

	localparam int Q_W     = 32;
	localparam int STEP_W  = 31;
	localparam int PROD_W  = 2 * Q_W;
	localparam int SQ_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W   = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;
	localparam int SPROD_W = COORD_WIDTH + STEP_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = Q_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C_RE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C_IM       = 3'd5;

	localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(4) << FRAC_BITS;

	typedef struct packed {
		logic        [ITER_WIDTH-1:0] max_iter;
		logic signed [Q_W-1:0]        origin_re;
		logic signed [Q_W-1:0]        origin_im;
		logic        [STEP_W-1:0]     pixel_step;
		logic signed [Q_W-1:0]        c_re;
		logic signed [Q_W-1:0]        c_im;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		max_iter:   12'd100,
		origin_re:  -32'sd90596966,
		origin_im:  -32'sd80530637,
		pixel_step: 31'd223696,
		c_re:       32'sd19125026,
		c_im:       32'sd671089
	};

	typedef struct packed {
		logic        [COORD_WIDTH-1:0] x;
		logic        [COORD_WIDTH-1:0] y;
		logic signed [Q_W-1:0]         zr;
		logic signed [Q_W-1:0]         zi;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQR,
		BK_SQI,
		BK_R3,
		BK_RI2,
		BK_R2I,
		BK_UPD,
		BK_DONE
	} bk_state_t;

	// Clamp a wide signed value to the signed Q word range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-Q_W:0] hi;
		logic signed [Q_W-1:0] r;
		hi = v[PROD_W-1:Q_W-1];
		if ((&hi) || !(|hi)) begin
			r = v[Q_W-1:0];
		end else if (v[PROD_W-1]) begin
			r = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(Q_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Fixed-point product rescale: floor shift, then saturate.
	function automatic logic signed [Q_W-1:0] qmul_post(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p >>> FRAC_BITS;
		return sat_q(s);
	endfunction

endpackage

/* src/cve_ifs.sv */
// ----------------------------------------------------------------------------
// cve_ifs: channel interfaces
// Valid/ready channels for pixel coordinates in and iteration results out.
// ----------------------------------------------------------------------------
interface cve_pix_if;
	logic                              valid;
	logic                              ready;
	logic [cve_pkg::COORD_WIDTH-1:0]   pixel_x;
	logic [cve_pkg::COORD_WIDTH-1:0]   pixel_y;

	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface cve_res_if;
	logic                              valid;
	logic                              ready;
	logic [cve_pkg::COORD_WIDTH-1:0]   out_x;
	logic [cve_pkg::COORD_WIDTH-1:0]   out_y;
	logic [cve_pkg::ITER_WIDTH-1:0]    iter_count;

	modport source(output valid, output out_x, output out_y, output iter_count, input ready);
	modport sink(input valid, input out_x, input out_y, input iter_count, output ready);
endinterface

/* src/cve_front.sv */
// ----------------------------------------------------------------------------
// cve_front: pixel intake
// Accepts pixel coordinates and maps them to start points in the plane,
// then pushes each job into the job queue.
// ----------------------------------------------------------------------------
module cve_front (
	input  logic              clk,
	input  logic              arst_n,
	input  cve_pkg::cfg_t     cfg,
	cve_pix_if.sink           pix,
	output logic              push_valid,
	input  logic              push_ready,
	output cve_pkg::job_t     push_data
);

	logic                                valid_s1;
	logic [cve_pkg::COORD_WIDTH-1:0]     x_s1;
	logic [cve_pkg::COORD_WIDTH-1:0]     y_s1;
	logic                                valid_s2;
	logic [cve_pkg::COORD_WIDTH-1:0]     x_s2;
	logic [cve_pkg::COORD_WIDTH-1:0]     y_s2;
	logic [cve_pkg::SPROD_W-1:0]         px_s2;
	logic [cve_pkg::SPROD_W-1:0]         py_s2;
	logic                                load_s1;
	logic                                load_s2;
	logic signed [cve_pkg::PROD_W-1:0]   zr_wide;
	logic signed [cve_pkg::PROD_W-1:0]   zi_wide;

	assign load_s2   = valid_s1 && (!valid_s2 || push_ready);
	assign pix.ready = !valid_s1 || load_s2;
	assign load_s1   = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= load_s1 || (valid_s1 && !load_s2);
			valid_s2 <= load_s2 || (valid_s2 && !push_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			x_s1 <= pix.pixel_x;
			y_s1 <= pix.pixel_y;
		end
		if (load_s2) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			px_s2 <= cve_pkg::SPROD_W'(x_s1) * cve_pkg::SPROD_W'(cfg.pixel_step);
			py_s2 <= cve_pkg::SPROD_W'(y_s1) * cve_pkg::SPROD_W'(cfg.pixel_step);
		end
	end

	always_comb begin
		zr_wide = cve_pkg::PROD_W'(cfg.origin_re) + signed'(cve_pkg::PROD_W'(px_s2));
		zi_wide = cve_pkg::PROD_W'(cfg.origin_im) + signed'(cve_pkg::PROD_W'(py_s2));
		push_data.x  = x_s2;
		push_data.y  = y_s2;
		push_data.zr = cve_pkg::sat_q(zr_wide);
		push_data.zi = cve_pkg::sat_q(zi_wide);
	end

	assign push_valid = valid_s2;

endmodule

/* src/cve_queue.sv */
// ----------------------------------------------------------------------------
// cve_queue: job queue
// Short first-in first-out buffer that decouples intake from iteration.
// ----------------------------------------------------------------------------
module cve_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  cve_pkg::job_t     push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output cve_pkg::job_t     pop_data
);

	cve_pkg::job_t                 mem_q [cve_pkg::QUEUE_DEPTH];
	logic [cve_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [cve_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [cve_pkg::QCNT_W-1:0]    cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = cnt_q != cve_pkg::QCNT_W'(cve_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	function automatic logic [cve_pkg::QPTR_W-1:0] next_ptr(input logic [cve_pkg::QPTR_W-1:0] p);
		logic [cve_pkg::QPTR_W-1:0] r;
		if (p == cve_pkg::QPTR_W'(cve_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/cve_back.sv */
// ----------------------------------------------------------------------------
// cve_back: iteration engine
// Runs the cubic update on one job at a time through a single shared
// multiplier and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module cve_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cve_pkg::cfg_t     cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  cve_pkg::job_t     pop_data,
	cve_res_if.source         res,
	output logic              busy
);

	cve_pkg::bk_state_t                  state_q;
	cve_pkg::bk_state_t                  state_nxt;

	logic [cve_pkg::COORD_WIDTH-1:0]     x_q;
	logic [cve_pkg::COORD_WIDTH-1:0]     y_q;
	logic signed [cve_pkg::Q_W-1:0]      zr_q;
	logic signed [cve_pkg::Q_W-1:0]      zi_q;
	logic [cve_pkg::ITER_WIDTH-1:0]      n_q;
	logic [cve_pkg::SQ_W-1:0]            sqr_q;
	logic signed [cve_pkg::Q_W-1:0]      r2_q;
	logic signed [cve_pkg::Q_W-1:0]      i2_q;
	logic signed [cve_pkg::Q_W-1:0]      r3_q;
	logic signed [cve_pkg::Q_W-1:0]      ri2_q;
	logic signed [cve_pkg::PROD_W-1:0]   prod_q;

	logic signed [cve_pkg::Q_W-1:0]      mul_a;
	logic signed [cve_pkg::Q_W-1:0]      mul_b;
	logic [cve_pkg::SUM_W-1:0]           mag_sum;
	logic                                escape;
	logic                                at_limit;
	logic                                out_free;
	logic                                out_load;
	logic signed [cve_pkg::Q_W-1:0]      prod_sat;
	logic signed [cve_pkg::PROD_W-1:0]   zr_wide;
	logic signed [cve_pkg::PROD_W-1:0]   zi_wide;

	logic                                out_valid_q;
	logic [cve_pkg::COORD_WIDTH-1:0]     out_x_q;
	logic [cve_pkg::COORD_WIDTH-1:0]     out_y_q;
	logic [cve_pkg::ITER_WIDTH-1:0]      out_n_q;

	assign out_free = !out_valid_q || res.ready;
	assign prod_sat = cve_pkg::qmul_post(prod_q);
	assign mag_sum  = cve_pkg::SUM_W'(sqr_q)
		+ cve_pkg::SUM_W'(prod_q[cve_pkg::PROD_W-1:cve_pkg::FRAC_BITS]);
	assign escape   = mag_sum >= cve_pkg::ESC_LIMIT;
	assign at_limit = n_q >= cfg.max_iter;

	always_comb begin
		zr_wide = cve_pkg::PROD_W'(r3_q)
			- ((cve_pkg::PROD_W'(ri2_q) <<< 1) + cve_pkg::PROD_W'(ri2_q))
			+ cve_pkg::PROD_W'(cfg.c_re);
		zi_wide = (cve_pkg::PROD_W'(prod_sat) <<< 1) + cve_pkg::PROD_W'(prod_sat)
			+ cve_pkg::PROD_W'(cfg.c_im);
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cve_pkg::BK_IDLE: begin
				if (pop_valid) begin
					state_nxt = cve_pkg::BK_SQR;
				end
			end
			cve_pkg::BK_SQR: begin
				state_nxt = at_limit ? cve_pkg::BK_DONE : cve_pkg::BK_SQI;
			end
			cve_pkg::BK_SQI: state_nxt = cve_pkg::BK_R3;
			cve_pkg::BK_R3: begin
				state_nxt = escape ? cve_pkg::BK_DONE : cve_pkg::BK_RI2;
			end
			cve_pkg::BK_RI2: state_nxt = cve_pkg::BK_R2I;
			cve_pkg::BK_R2I: state_nxt = cve_pkg::BK_UPD;
			cve_pkg::BK_UPD: state_nxt = cve_pkg::BK_SQR;
			cve_pkg::BK_DONE: begin
				if (out_free) begin
					state_nxt = cve_pkg::BK_IDLE;
				end
			end
			default: state_nxt = cve_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		out_load  = 1'b0;
		mul_a     = zr_q;
		mul_b     = zr_q;
		unique case (state_q)
			cve_pkg::BK_IDLE: pop_ready = 1'b1;
			cve_pkg::BK_SQR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			cve_pkg::BK_SQI: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			cve_pkg::BK_R3: begin
				mul_a = r2_q;
				mul_b = zr_q;
			end
			cve_pkg::BK_RI2: begin
				mul_a = zr_q;
				mul_b = i2_q;
			end
			cve_pkg::BK_R2I: begin
				mul_a = r2_q;
				mul_b = zi_q;
			end
			cve_pkg::BK_UPD: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			cve_pkg::BK_DONE: out_load = out_free;
			default: pop_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cve_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= out_load || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			cve_pkg::BK_IDLE: begin
				if (pop_valid) begin
					x_q  <= pop_data.x;
					y_q  <= pop_data.y;
					zr_q <= pop_data.zr;
					zi_q <= pop_data.zi;
					n_q  <= '0;
				end
			end
			cve_pkg::BK_SQI: begin
				sqr_q <= prod_q[cve_pkg::PROD_W-1:cve_pkg::FRAC_BITS];
				r2_q  <= prod_sat;
			end
			cve_pkg::BK_R3:  i2_q  <= prod_sat;
			cve_pkg::BK_RI2: r3_q  <= prod_sat;
			cve_pkg::BK_R2I: ri2_q <= prod_sat;
			cve_pkg::BK_UPD: begin
				zr_q <= cve_pkg::sat_q(zr_wide);
				zi_q <= cve_pkg::sat_q(zi_wide);
				n_q  <= n_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_x_q <= x_q;
			out_y_q <= y_q;
			out_n_q <= n_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_x      = out_x_q;
	assign res.out_y      = out_y_q;
	assign res.iter_count = out_n_q;
	assign busy           = state_q != cve_pkg::BK_IDLE;

endmodule

/* src/cubic_variant_escape_time_core.sv */
// ----------------------------------------------------------------------------
// cubic_variant_escape_time_core: cubic escape-time iteration per pixel
// Maps a pixel coordinate to a start point and counts cubic iterations
// until the point escapes or the configured limit is reached.
// ----------------------------------------------------------------------------
// Each pixel transfer is turned into a start point by a two-stage intake and
// placed in a two-entry job queue, so the intake keeps taking pixels while
// the iteration engine works. The engine handles one pixel at a time with a
// single 32x32 multiplier that forms five products per iteration. The result
// sits in an output register; the engine goes on to the next pixel while it
// waits. Configuration writes take effect at once and are meant for times
// when no pixel is in flight.
module cubic_variant_escape_time_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [cve_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cve_pkg::CFG_DATA_W-1:0]     cfg_data,
	cve_pix_if.sink                            pixel,
	cve_res_if.source                          result
);

	cve_pkg::cfg_t    cfg_q;
	logic             q_push_valid;
	logic             q_push_ready;
	cve_pkg::job_t    q_push_data;
	logic             q_pop_valid;
	logic             q_pop_ready;
	cve_pkg::job_t    q_pop_data;
	logic             bk_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cve_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cve_pkg::REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data[cve_pkg::ITER_WIDTH-1:0];
				cve_pkg::REG_ORIGIN_RE:  cfg_q.origin_re  <= signed'(cfg_data);
				cve_pkg::REG_ORIGIN_IM:  cfg_q.origin_im  <= signed'(cfg_data);
				cve_pkg::REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data[cve_pkg::STEP_W-1:0];
				cve_pkg::REG_C_RE:       cfg_q.c_re       <= signed'(cfg_data);
				cve_pkg::REG_C_IM:       cfg_q.c_im       <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	cve_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pix        (pixel),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	cve_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	cve_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data),
		.res        (result),
		.busy       (bk_busy)
	);

	// A job taken from the queue keeps the engine busy in the next cycle.
	a_pop_starts_engine: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop_valid && q_pop_ready) |=> bk_busy)
		else $error("queue transfer did not start the iteration engine");

	// When the engine frees up, its result is waiting at the output.
	a_finish_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bk_busy) |-> result.valid)
		else $error("engine finished without presenting a result");

endmodule
